FILE: sv/bzc_pkg.sv
// Shared constants and types for the Bezier curve point evaluator.
package bzc_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned U_W        = 17;
  localparam int unsigned POINT_W    = 48;
  localparam int unsigned NUM_POINTS = 4;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [U_W-1:0]     U_ONE    = 17'h10000;
  localparam logic [COORD_W-1:0] SIGN_BIT = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POINT_ZERO  = 3'd0,
    REG_POINT_ONE   = 3'd1,
    REG_POINT_TWO   = 3'd2,
    REG_POINT_THREE = 3'd3
  } cfg_reg_e;

  localparam logic [POINT_W-1:0] POINT_RST [NUM_POINTS] = '{
    48'h0000_FE00_0400,
    48'h0000_F800_0100,
    48'h0000_FF00_0C00,
    48'h0000_FB00_0200
  };

endpackage

FILE: sv/bzc_cell.sv
// One de Casteljau cell: registered exact lerp of two neighbouring points.
module bzc_cell #(
  parameter int unsigned IN_W = 16
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [bzc_pkg::U_W-1:0]   u_i,
  input  logic [IN_W-1:0]           lo_i,
  input  logic [IN_W-1:0]           hi_i,
  output logic [IN_W+15:0]          val_o
);
  import bzc_pkg::*;

  localparam int unsigned OUT_W = IN_W + COORD_W;
  localparam int unsigned PW    = IN_W + U_W;

  logic signed [PW-1:0] lo_s, hi_s, u_s, sum_s;
  logic [OUT_W-1:0]     val_q;

  // lo*(65536-u) + hi*u, rewritten as lo*65536 + (hi-lo)*u; exact, never negative
  always_comb begin
    lo_s  = $signed(PW'(lo_i));
    hi_s  = $signed(PW'(hi_i));
    u_s   = $signed(PW'(u_i));
    sum_s = (lo_s <<< COORD_W) + (hi_s - lo_s) * u_s;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= sum_s[OUT_W-1:0];
    end
  end

  assign val_o = val_q;

endmodule

FILE: sv/bezier_curve_point_eval.sv
// Bezier curve point evaluator: a triangle of cells, one de Casteljau level per row.
// An item enters every cycle unless stalled and passes the cell rows, one registered
// de Casteljau level each, sustaining one point per clock unless stalled. Every row is
// exact (it widens by 16 bits), and the last row is rounded to Q8.8, ties toward plus
// infinity. When a finished point is held by the consumer the whole row pipeline stalls
// together. Control points come through the configuration channel, indexes 0 to 3; the
// user writes them only while no item is in flight, which the block does not enforce.
module bezier_curve_point_eval #(
  parameter int DEGREE = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bzc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bzc_pkg::POINT_W-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bzc_pkg::U_W-1:0]          param_u_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [bzc_pkg::COORD_W-1:0] pos_x_o,
  output logic signed [bzc_pkg::COORD_W-1:0] pos_y_o,
  output logic signed [bzc_pkg::COORD_W-1:0] pos_z_o
);
  import bzc_pkg::*;

  localparam int unsigned DEG = (DEGREE < 1) ? 1 : ((DEGREE > 7) ? 7 : DEGREE);
  localparam int unsigned FW  = COORD_W * (DEG + 1);

  logic [POINT_W-1:0] point_q [NUM_POINTS];
  logic [FW-1:0]      lvl [DEG+1][DEG+1][3];
  logic [U_W-1:0]     u_pipe [DEG];
  logic [DEG-1:0]     vld_q;
  logic               en;
  logic [COORD_W-1:0] res [3];
  logic [2:0]         rnd_ovf;

  // control point registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        point_q[i] <= POINT_RST[i];
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_POINT_ZERO:  point_q[0] <= cfg_data_i;
        REG_POINT_ONE:   point_q[1] <= cfg_data_i;
        REG_POINT_TWO:   point_q[2] <= cfg_data_i;
        REG_POINT_THREE: point_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // whole pipeline moves unless a finished point is held
  assign en         = !vld_q[DEG-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < DEG; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign u_pipe[0] = (param_u_i > U_ONE) ? U_ONE : param_u_i;

  for (genvar k = 1; k < DEG; k++) begin : g_upipe
    logic [U_W-1:0] u_q;
    always_ff @(posedge clk_i) begin
      if (en) begin
        u_q <= u_pipe[k-1];
      end
    end
    assign u_pipe[k] = u_q;
  end

  // level 0: control points as offset-binary coordinates; missing points read as zero
  for (genvar i = 0; i <= DEG; i++) begin : g_lvl0
    for (genvar c = 0; c < 3; c++) begin : g_crd
      if (i < NUM_POINTS) begin : g_reg
        assign lvl[0][i][c] = FW'(point_q[i][COORD_W*c +: COORD_W] ^ SIGN_BIT);
      end else begin : g_zero
        assign lvl[0][i][c] = FW'(SIGN_BIT);
      end
    end
  end

  // rows of cells, row k holds level k
  for (genvar k = 1; k <= DEG; k++) begin : g_row
    localparam int unsigned IW = COORD_W * k;
    for (genvar i = 0; i <= DEG; i++) begin : g_col
      for (genvar c = 0; c < 3; c++) begin : g_crd
        if (i <= DEG - k) begin : g_cell
          logic [IW+COORD_W-1:0] val;
          bzc_cell #(
            .IN_W (IW)
          ) u_cell (
            .clk_i (clk_i),
            .en_i  (en),
            .u_i   (u_pipe[k-1]),
            .lo_i  (lvl[k-1][i][c][IW-1:0]),
            .hi_i  (lvl[k-1][i+1][c][IW-1:0]),
            .val_o (val)
          );
          assign lvl[k][i][c] = FW'(val);
        end else begin : g_none
          assign lvl[k][i][c] = '0;
        end
      end
    end
  end

  // round half up on the top 16 bits; hull keeps it from wrapping
  for (genvar c = 0; c < 3; c++) begin : g_rnd
    assign res[c]     = lvl[DEG][0][c][FW-1 -: COORD_W]
                        + COORD_W'(lvl[DEG][0][c][COORD_W*DEG-1]);
    assign rnd_ovf[c] = (&lvl[DEG][0][c][FW-1 -: COORD_W]) & lvl[DEG][0][c][COORD_W*DEG-1];
  end

  assign out_valid_o = vld_q[DEG-1];
  assign pos_x_o     = $signed(res[0] ^ SIGN_BIT);
  assign pos_y_o     = $signed(res[1] ^ SIGN_BIT);
  assign pos_z_o     = $signed(res[2] ^ SIGN_BIT);

`ifndef SYNTHESIS
  a_first_row_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted item missing from first row");

  a_round_in_hull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rnd_ovf == 3'b000)
    else $error("rounded point left the hull");

  a_bad_index_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o && (cfg_index_i > REG_POINT_THREE) |=>
      point_q[0] == $past(point_q[0]) && point_q[1] == $past(point_q[1]) &&
      point_q[2] == $past(point_q[2]) && point_q[3] == $past(point_q[3]))
    else $error("write to unknown index changed a control point");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the cubic Bezier curve point evaluator.
module testbench;
  import bzc_pkg::*;

  localparam int          CURVE_DEGREE = 3;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_ITEMS  = 260;
  localparam int unsigned PT_IDX_W     = $clog2(NUM_POINTS);

  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED = CFG_IDX_W'(NUM_POINTS);
  localparam logic [POINT_W-1:0]   PT_MAX       = 48'h7FFF_7FFF_7FFF;
  localparam logic [POINT_W-1:0]   PT_MIN       = 48'h8000_8000_8000;

  localparam logic [U_W-1:0] EDGE_U [8] = '{
    17'd0, 17'd1, 17'd32767, 17'd32768, 17'd65535, 17'd65536, 17'd65537, 17'h1FFFF
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef enum int {
    TR_FREE, TR_SEND_IDLE, TR_RECV_STALL, TR_BOTH_IDLE, TR_HOLDOFF
  } traffic_e;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [POINT_W-1:0]     cfg_data_i  = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic [U_W-1:0]         param_u_i   = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic signed [COORD_W-1:0] pos_x_o, pos_y_o, pos_z_o;

  logic [POINT_W-1:0] ctrl_pts [NUM_POINTS];
  logic [U_W-1:0]     pending_params [$];
  point_t             expected_points [$];

  traffic_e    traffic      = TR_FREE;
  traffic_e    last_traffic = TR_FREE;
  int unsigned hold_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors       = 0;
  logic        in_fire_q    = 1'b0;
  logic        cfg_fire_q   = 1'b0;

  bezier_curve_point_eval #(
    .DEGREE(CURVE_DEGREE)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .param_u_i  (param_u_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pos_x_o    (pos_x_o),
    .pos_y_o    (pos_y_o),
    .pos_z_o    (pos_z_o)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Exact Bernstein sum in offset-binary, then round half up on the last 16-bit unit.
  function automatic logic [COORD_W-1:0] bezier_coord(input logic [U_W-1:0] u_raw,
                                                      input int unsigned axis);
    logic [U_W-1:0]     u, v;
    logic [159:0]       sum, term;
    logic [63:0]        binom;
    logic [POINT_W-1:0] pt;
    u     = (u_raw > U_ONE) ? U_ONE : u_raw;
    v     = U_ONE - u;
    sum   = '0;
    binom = 64'd1;
    for (int i = 0; i <= CURVE_DEGREE; i++) begin
      if (i > 0) begin
        binom = binom * (CURVE_DEGREE - i + 1) / i;
      end
      term = 160'(binom);
      for (int j = 0; j < i; j++) term = term * u;
      for (int j = i; j < CURVE_DEGREE; j++) term = term * v;
      pt   = (i < NUM_POINTS) ? ctrl_pts[i] : '0;
      term = term * (pt[axis*COORD_W +: COORD_W] ^ SIGN_BIT);
      sum  = sum + term;
    end
    sum = sum + (160'd1 << (CURVE_DEGREE*COORD_W - 1));
    return sum[CURVE_DEGREE*COORD_W +: COORD_W] ^ SIGN_BIT;
  endfunction

  function automatic point_t predict_point(input logic [U_W-1:0] u_raw);
    point_t p;
    p.x = bezier_coord(u_raw, 0);
    p.y = bezier_coord(u_raw, 1);
    p.z = bezier_coord(u_raw, 2);
    return p;
  endfunction

  function automatic int unsigned send_idle_pct(input traffic_e tr);
    return (tr == TR_SEND_IDLE) ? 66 : (tr == TR_BOTH_IDLE) ? 32 : 0;
  endfunction

  function automatic int unsigned recv_stall_pct(input traffic_e tr);
    return (tr == TR_RECV_STALL) ? 66 : (tr == TR_BOTH_IDLE) ? 32 : 0;
  endfunction

  function automatic logic [POINT_W-1:0] rand_point();
    logic [POINT_W-1:0] p;
    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(9))
        0:       p[c*COORD_W +: COORD_W] = 16'h7FFF;
        1:       p[c*COORD_W +: COORD_W] = 16'h8000;
        default: p[c*COORD_W +: COORD_W] = COORD_W'($urandom);
      endcase
    end
    return p;
  endfunction

  function automatic logic [U_W-1:0] rand_param();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) begin
      return ($urandom_range(1) != 0) ? U_ONE : '0;
    end else if (pick < 15) begin
      return U_W'($urandom_range(17'h1FFFF, 17'd65537));
    end
    return U_W'($urandom_range(65536));
  endfunction

  task automatic check_coord(input string axis, input logic signed [COORD_W-1:0] exp_v,
                             input logic signed [COORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: pos_%s mismatch, expected %0d got %0d", $time, axis, exp_v, act_v);
    end
  endtask

  // Sender: new item only once the current one has transferred.
  always @(negedge clk) begin
    if (rst_ni && (!in_valid_i || in_fire_q)) begin
      if (pending_params.size() > 0 && $urandom_range(99) >= send_idle_pct(traffic)) begin
        in_valid_i <= 1'b1;
        param_u_i  <= pending_params.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver, with a long hold-off at the start of the hold-off phase.
  always @(negedge clk) begin
    if (traffic != last_traffic) begin
      last_traffic <= traffic;
      hold_count   <= 0;
    end else if (hold_count < HOLD_CYCLES) begin
      hold_count <= hold_count + 1;
    end
    if (traffic == TR_HOLDOFF && hold_count < HOLD_CYCLES) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct(traffic));
    end
  end

  // Monitor: tracks transfers, predicts, checks and runs the watchdog.
  always @(posedge clk) begin
    point_t want;
    if (!rst_ni) begin
      ctrl_pts   = POINT_RST;
      in_fire_q  <= 1'b0;
      cfg_fire_q <= 1'b0;
    end else begin
      in_fire_q  <= in_valid_i && in_ready_o;
      cfg_fire_q <= cfg_valid_i && cfg_ready_o;
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < NUM_POINTS) begin
        ctrl_pts[cfg_index_i[PT_IDX_W-1:0]] = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        expected_points.push_back(predict_point(param_u_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_points.size() == 0) begin
          errors++;
          $display("%0t: unexpected point, got %0d %0d %0d", $time, pos_x_o, pos_y_o,
                   pos_z_o);
        end else begin
          want = expected_points.pop_front();
          check_coord("x", want.x, pos_x_o);
          check_coord("y", want.y, pos_y_o);
          check_coord("z", want.z, pos_z_o);
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic write_point(input logic [CFG_IDX_W-1:0] idx, input logic [POINT_W-1:0] data);
    @(negedge clk);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk); while (!cfg_fire_q);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_points(input logic [POINT_W-1:0] p0, input logic [POINT_W-1:0] p1,
                             input logic [POINT_W-1:0] p2, input logic [POINT_W-1:0] p3);
    write_point(REG_POINT_ZERO, p0);
    write_point(REG_POINT_ONE, p1);
    write_point(REG_POINT_TWO, p2);
    write_point(REG_POINT_THREE, p3);
  endtask

  task automatic drain();
    while (pending_params.size() != 0 || in_valid_i || expected_points.size() != 0) begin
      @(negedge clk);
    end
    repeat (CURVE_DEGREE + 3) @(posedge clk);
  endtask

  task automatic push_edges();
    foreach (EDGE_U[k]) pending_params.push_back(EDGE_U[k]);
  endtask

  task automatic run_random(input traffic_e tr);
    traffic = tr;
    repeat (PHASE_ITEMS) pending_params.push_back(rand_param());
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(posedge clk);

    // corner parameters on the reset curve, then on the hull extremes
    traffic = TR_FREE;
    push_edges();
    drain();
    load_points(PT_MAX, PT_MAX, PT_MAX, PT_MAX);
    push_edges();
    drain();
    load_points(PT_MIN, PT_MAX, PT_MIN, PT_MAX);
    push_edges();
    drain();

    load_points(PT_MAX, PT_MIN, PT_MIN, PT_MAX);
    run_random(TR_FREE);
    load_points(rand_point(), rand_point(), rand_point(), rand_point());
    run_random(TR_SEND_IDLE);
    load_points(rand_point(), rand_point(), rand_point(), rand_point());
    run_random(TR_RECV_STALL);
    // writes above the last point register must leave the curve alone
    load_points(rand_point(), rand_point(), rand_point(), rand_point());
    write_point(IDX_UNMAPPED, rand_point());
    write_point(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, NUM_POINTS)), rand_point());
    run_random(TR_BOTH_IDLE);
    load_points(rand_point(), rand_point(), rand_point(), rand_point());
    run_random(TR_HOLDOFF);

    traffic = TR_FREE;
    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/bzc_pkg.sv
sv/bzc_cell.sv
sv/bezier_curve_point_eval.sv
tb/testbench.sv
